FILE: rtl/core/nopa_pkg.sv
package nopa_pkg;

    // default configuration of the arbiter
    localparam int NUM_PORTS_DEF  = 5;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int MODE_W         = 2;

    // policy applied when all requesters show the same arrival time
    typedef enum logic [MODE_W-1:0] {
        MODE_EARLIEST = 2'd0,
        MODE_LRU      = 2'd1,
        MODE_RR       = 2'd2,
        MODE_FIXED    = 2'd3
    } t_mode;

    // control handed from the input register to the decision and result stages
    typedef struct packed {
        logic advance;
    } t_stage_ctl;

endpackage

FILE: rtl/core/nopa_ifs.sv
// request channel: one word per arbitration
interface nopa_req_if #(
    parameter int NUM_PORTS  = nopa_pkg::NUM_PORTS_DEF,
    parameter int TIME_WIDTH = nopa_pkg::TIME_WIDTH_DEF
);
    logic                                 valid;
    logic                                 ready;
    logic [NUM_PORTS-1:0]                 request_mask;
    logic [NUM_PORTS-1:0][TIME_WIDTH-1:0] arrival;

    modport source (output valid, output request_mask, output arrival, input ready);
    modport sink   (input valid, input request_mask, input arrival, output ready);
endinterface

// grant channel: one word per request word
interface nopa_grant_if #(
    parameter int NUM_PORTS = nopa_pkg::NUM_PORTS_DEF
);
    localparam int PW = $clog2(NUM_PORTS);

    logic          valid;
    logic          ready;
    logic          grant_valid;
    logic [PW-1:0] grant_port;

    modport source (output valid, output grant_valid, output grant_port, input ready);
    modport sink   (input valid, input grant_valid, input grant_port, output ready);
endinterface

// configuration write channel: arbitration mode
interface nopa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [nopa_pkg::MODE_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/nopa_in_stage.sv
module nopa_in_stage #(
    parameter int NUM_PORTS  = nopa_pkg::NUM_PORTS_DEF,
    parameter int TIME_WIDTH = nopa_pkg::TIME_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [NUM_PORTS-1:0]                 i_mask,
    input  logic [NUM_PORTS-1:0][TIME_WIDTH-1:0] i_arrival,
    input  logic                                 i_out_free,
    output nopa_pkg::t_stage_ctl                 o_ctl,
    output logic [NUM_PORTS-1:0]                 o_mask,
    output logic [NUM_PORTS-1:0][TIME_WIDTH-1:0] o_arrival
);
    import nopa_pkg::*;

    logic                                 r_valid;
    logic                                 n_valid;
    logic [NUM_PORTS-1:0]                 r_mask;
    logic [NUM_PORTS-1:0][TIME_WIDTH-1:0] r_arrival;
    logic                                 w_take;

    // advance the held word when the result register can take it
    always_comb begin
        o_ctl.advance = r_valid & i_out_free;
        o_ready       = ~r_valid | i_out_free;
        w_take        = i_valid & o_ready;
        n_valid       = w_take | (r_valid & ~i_out_free);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // capture a new request word
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_mask    <= i_mask;
            r_arrival <= i_arrival;
        end
    end

    assign o_mask    = r_mask;
    assign o_arrival = r_arrival;

endmodule

FILE: rtl/core/nopa_arb.sv
module nopa_arb #(
    parameter int NUM_PORTS  = nopa_pkg::NUM_PORTS_DEF,
    parameter int TIME_WIDTH = nopa_pkg::TIME_WIDTH_DEF,
    localparam int PW        = $clog2(NUM_PORTS)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  nopa_pkg::t_stage_ctl                 i_ctl,
    input  nopa_pkg::t_mode                      i_mode,
    input  logic [NUM_PORTS-1:0]                 i_mask,
    input  logic [NUM_PORTS-1:0][TIME_WIDTH-1:0] i_arrival,
    output logic                                 o_grant_valid,
    output logic [PW-1:0]                        o_grant_port
);
    import nopa_pkg::*;

    localparam int N = NUM_PORTS;

    logic [N-1:0][PW-1:0] r_order;
    logic [N-1:0][PW-1:0] n_order;
    logic [PW-1:0]        r_rr_ptr;
    logic [PW-1:0]        n_rr_ptr;

    logic [N-1:0][N-1:0]  w_lt;
    logic                 w_any;
    logic                 w_differ;
    logic [N-1:0]         w_e_hot;
    logic [PW-1:0]        w_e_win;
    logic [N-1:0]         w_rr_hi;
    logic [N-1:0]         w_rr_hot;
    logic [PW-1:0]        w_rr_win;
    logic [N-1:0]         w_hit;
    logic [N-1:0]         w_o_hot;
    logic [PW-1:0]        w_k_sel;
    logic [PW-1:0]        w_o_win;
    logic                 w_upd_order;
    logic                 w_upd_ptr;

    function automatic logic [PW-1:0] enc(input logic [N-1:0] hot);
        logic [PW-1:0] idx;
        idx = '0;
        for (int i = 0; i < N; i++) begin
            if (hot[i]) begin
                idx = idx | PW'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [N-1:0] lowest(input logic [N-1:0] x);
        return x & (~x + N'(1));
    endfunction

    // pairwise arrival compares feed both the tie test and the earliest pick
    always_comb begin
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                w_lt[i][j] = i_arrival[i] < i_arrival[j];
            end
        end
        w_any    = |i_mask;
        w_differ = 1'b0;
        for (int i = 0; i < N; i++) begin
            for (int j = 0; j < N; j++) begin
                w_differ = w_differ | (i_mask[i] & i_mask[j] & w_lt[i][j]);
            end
        end
    end

    // earliest arrival; equal times go to the higher port
    always_comb begin
        for (int i = 0; i < N; i++) begin
            w_e_hot[i] = i_mask[i];
            for (int j = 0; j < N; j++) begin
                if (j != i) begin
                    if (i_mask[j] && !(w_lt[i][j] || (!w_lt[j][i] && (i > j)))) begin
                        w_e_hot[i] = 1'b0;
                    end
                end
            end
        end
        w_e_win = enc(w_e_hot);
    end

    // round robin: first requester at or above the pointer, else wrap
    always_comb begin
        w_rr_hi  = i_mask & ~((N'(1) << r_rr_ptr) - N'(1));
        w_rr_hot = (|w_rr_hi) ? lowest(w_rr_hi) : lowest(i_mask);
        w_rr_win = enc(w_rr_hot);
    end

    // order list walk for lru and fixed
    always_comb begin
        for (int k = 0; k < N; k++) begin
            w_hit[k] = ({1'b0, r_order[k]} < (PW+1)'(N)) && i_mask[r_order[k]];
        end
        w_o_hot = lowest(w_hit);
        w_k_sel = enc(w_o_hot);
        w_o_win = r_order[w_k_sel];
    end

    // choose the grant and the state update
    always_comb begin
        o_grant_valid = 1'b0;
        o_grant_port  = '0;
        w_upd_order   = 1'b0;
        w_upd_ptr     = 1'b0;
        if (w_any) begin
            if (w_differ || i_mode == MODE_EARLIEST) begin
                o_grant_valid = 1'b1;
                o_grant_port  = w_e_win;
            end else begin
                case (i_mode)
                    MODE_RR: begin
                        o_grant_valid = 1'b1;
                        o_grant_port  = w_rr_win;
                        w_upd_ptr     = 1'b1;
                    end
                    MODE_LRU: begin
                        o_grant_valid = |w_hit;
                        o_grant_port  = (|w_hit) ? w_o_win : '0;
                        w_upd_order   = |w_hit;
                    end
                    MODE_FIXED: begin
                        o_grant_valid = |w_hit;
                        o_grant_port  = (|w_hit) ? w_o_win : '0;
                    end
                    default: begin
                        o_grant_valid = 1'b1;
                        o_grant_port  = w_e_win;
                    end
                endcase
            end
        end
    end

    // next pointer and order list: move the lru winner to the end
    always_comb begin
        n_rr_ptr = r_rr_ptr;
        n_order  = r_order;
        if (w_upd_ptr) begin
            n_rr_ptr = (w_rr_win == PW'(N - 1)) ? '0 : w_rr_win + PW'(1);
        end
        if (w_upd_order) begin
            for (int i = 0; i < N - 1; i++) begin
                n_order[i] = (PW'(i) >= w_k_sel) ? r_order[i + 1] : r_order[i];
            end
            n_order[N - 1] = w_o_win;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rr_ptr <= '0;
            for (int i = 0; i < N; i++) begin
                r_order[i] <= PW'(i);
            end
        end else if (i_ctl.advance) begin
            r_rr_ptr <= n_rr_ptr;
            r_order  <= n_order;
        end
    end

endmodule

FILE: rtl/core/nopa_out_stage.sv
module nopa_out_stage #(
    parameter int NUM_PORTS = nopa_pkg::NUM_PORTS_DEF,
    localparam int PW       = $clog2(NUM_PORTS)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nopa_pkg::t_stage_ctl i_ctl,
    input  logic                 i_grant_valid,
    input  logic [PW-1:0]        i_grant_port,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_grant_valid,
    output logic [PW-1:0]        o_grant_port
);
    import nopa_pkg::*;

    logic          r_valid;
    logic          n_valid;
    logic          r_grant_valid;
    logic [PW-1:0] r_grant_port;

    // hold the result until the sink takes it
    always_comb begin
        o_free  = ~r_valid | i_ready;
        n_valid = i_ctl.advance | (r_valid & ~i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // load a fresh grant word
    always_ff @(posedge i_clk) begin
        if (i_ctl.advance) begin
            r_grant_valid <= i_grant_valid;
            r_grant_port  <= i_grant_port;
        end
    end

    assign o_valid       = r_valid;
    assign o_grant_valid = r_grant_valid;
    assign o_grant_port  = r_grant_port;

endmodule

FILE: rtl/core/noc_output_port_arbiter_top.sv
// channel   | dir | handshake     | word
// ----------+-----+---------------+-------------------------------------------
// i_cfg     | in  | valid / ready | data: arbitration mode, 2 bits
// i_req     | in  | valid / ready | request_mask, arrival[NUM_PORTS]
// o_grant   | out | valid / ready | grant_valid, grant_port
//
// One request word per cycle while i_req.ready is high; a grant word passes
// through the input and result registers that sit around the
// single-pass compare and order-list logic.
// Synchronous active-low reset clears both valid flags, the mode (earliest
// first), the order list (identity) and the round-robin pointer (zero).
// A held grant drops i_req.ready once the input register is full; config is always taken.
module noc_output_port_arbiter_top #(
    parameter int NUM_PORTS  = nopa_pkg::NUM_PORTS_DEF,
    parameter int TIME_WIDTH = nopa_pkg::TIME_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    nopa_cfg_if.sink     i_cfg,
    nopa_req_if.sink     i_req,
    nopa_grant_if.source o_grant
);
    import nopa_pkg::*;

    localparam int PW = $clog2(NUM_PORTS);

    t_mode                                r_mode;
    t_mode                                n_mode;
    t_stage_ctl                           w_ctl;
    logic [NUM_PORTS-1:0]                 w_mask;
    logic [NUM_PORTS-1:0][TIME_WIDTH-1:0] w_arrival;
    logic                                 w_out_free;
    logic                                 w_grant_valid;
    logic [PW-1:0]                        w_grant_port;

    // mode register, written from the configuration channel
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_mode = r_mode;
        if (i_cfg.valid) begin
            n_mode = t_mode'(i_cfg.data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_EARLIEST;
        end else begin
            r_mode <= n_mode;
        end
    end

    nopa_in_stage #(
        .NUM_PORTS  (NUM_PORTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_in_stage (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_req.valid),
        .o_ready    (i_req.ready),
        .i_mask     (i_req.request_mask),
        .i_arrival  (i_req.arrival),
        .i_out_free (w_out_free),
        .o_ctl      (w_ctl),
        .o_mask     (w_mask),
        .o_arrival  (w_arrival)
    );

    nopa_arb #(
        .NUM_PORTS  (NUM_PORTS),
        .TIME_WIDTH (TIME_WIDTH)
    ) u_arb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_mode        (r_mode),
        .i_mask        (w_mask),
        .i_arrival     (w_arrival),
        .o_grant_valid (w_grant_valid),
        .o_grant_port  (w_grant_port)
    );

    nopa_out_stage #(
        .NUM_PORTS (NUM_PORTS)
    ) u_out_stage (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_grant_valid (w_grant_valid),
        .i_grant_port  (w_grant_port),
        .o_free        (w_out_free),
        .o_valid       (o_grant.valid),
        .i_ready       (o_grant.ready),
        .o_grant_valid (o_grant.grant_valid),
        .o_grant_port  (o_grant.grant_port)
    );

endmodule

FILE: rtl/core/nopa_checker.sv
module nopa_checker #(
    parameter int NUM_PORTS = nopa_pkg::NUM_PORTS_DEF,
    localparam int PW       = $clog2(NUM_PORTS)
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          i_ready,
    input logic          i_grant_valid,
    input logic [PW-1:0] i_grant_port
);

    // a stalled grant word keeps its valid
    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid)
        else $error("grant valid dropped while stalled");

    // a stalled grant word keeps its payload
    a_word_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> $stable(i_grant_valid) && $stable(i_grant_port))
        else $error("grant word changed while stalled");

    // a granted port is one of the input ports
    a_port_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_grant_valid |-> {1'b0, i_grant_port} < (PW+1)'(NUM_PORTS))
        else $error("grant port out of range");

    // an empty grant word reports port zero
    a_idle_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_grant_valid |-> i_grant_port == '0)
        else $error("empty grant carries a port");

endmodule

bind noc_output_port_arbiter_top nopa_checker #(
    .NUM_PORTS (NUM_PORTS)
) u_nopa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (o_grant.valid),
    .i_ready       (o_grant.ready),
    .i_grant_valid (o_grant.grant_valid),
    .i_grant_port  (o_grant.grant_port)
);
